// ----- src/afc_pkg.sv -----
// Package for the box/frustum classifier: widths, payload structs, status
// and verdict codes shared by the interfaces, the plane lane and the top level.
// No dependencies.
package afc_pkg;

  localparam int NUM_PLANES = 6;
  localparam int COORD_BITS = 16;

  localparam int COEF_W    = 16;
  localparam int FRAC_BITS = 14;
  localparam int PLANE_W   = 4 * COEF_W;
  localparam int NORMAL_W  = 3 * COEF_W;
  localparam int HINT_W    = 3;
  localparam int HINT_SLOTS = 1 << HINT_W;
  localparam int CFG_IDX_W = 3;

  localparam int PROD_W  = COORD_BITS + COEF_W;
  localparam int DTERM_W = COEF_W + FRAC_BITS;
  localparam int SUM_W   = ((PROD_W > DTERM_W) ? PROD_W : DTERM_W) + 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]     coef_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [DTERM_W-1:0]    dterm_t;
  typedef logic signed [SUM_W-1:0]      sum_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_BOX     = 2'd1,
    ST_BAD_HINT    = 2'd2,
    ST_ZERO_NORMAL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    VD_INSIDE    = 2'd0,
    VD_INTERSECT = 2'd1,
    VD_OUTSIDE   = 2'd2
  } verdict_t;

  typedef struct packed {
    coef_t d;
    coef_t c;
    coef_t b;
    coef_t a;
  } plane_t;

  typedef struct packed {
    coord_t            min_x;
    coord_t            min_y;
    coord_t            min_z;
    coord_t            max_x;
    coord_t            max_y;
    coord_t            max_z;
    logic              hint_valid;
    logic [HINT_W-1:0] hint_index;
  } box_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] verdict;
    logic       plane_found;
    logic [2:0] separating_plane;
  } result_t;

  typedef struct packed {
    logic sep;
    logic cut;
  } plane_class_t;

endpackage

// ----- src/afc_stream_if.sv -----
// Valid/ready channel interfaces for box transactions and result transactions.
// Depends on afc_pkg for the payload structs.
interface afc_box_if import afc_pkg::*; ();
  logic valid;
  logic ready;
  box_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface afc_res_if import afc_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/afc_plane_eval.sv -----
// One plane lane: positive/negative vertex products, then the two distances
// and their signs. Two register stages, advanced together by en.
// Depends on afc_pkg.
module afc_plane_eval import afc_pkg::*; (
  input  logic         clk,
  input  logic         en,
  input  plane_t       plane,
  input  box_t         box,
  output plane_class_t cls
);

  coef_t  n  [3];
  coord_t lo [3];
  coord_t hi [3];

  prod_t  pos_prod_r [3];
  prod_t  neg_prod_r [3];
  dterm_t dterm_r;
  sum_t   pos_sum;
  sum_t   neg_sum;
  plane_class_t cls_r;

  always_comb begin
    n[0]  = plane.a;
    n[1]  = plane.b;
    n[2]  = plane.c;
    lo[0] = box.min_x;
    lo[1] = box.min_y;
    lo[2] = box.min_z;
    hi[0] = box.max_x;
    hi[1] = box.max_y;
    hi[2] = box.max_z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (!n[k][COEF_W-1]) begin
          pos_prod_r[k] <= PROD_W'(n[k]) * PROD_W'(hi[k]);
          neg_prod_r[k] <= PROD_W'(n[k]) * PROD_W'(lo[k]);
        end else begin
          pos_prod_r[k] <= PROD_W'(n[k]) * PROD_W'(lo[k]);
          neg_prod_r[k] <= PROD_W'(n[k]) * PROD_W'(hi[k]);
        end
      end
      dterm_r <= {plane.d, FRAC_BITS'(0)};
    end
  end

  assign pos_sum = SUM_W'(pos_prod_r[0]) + SUM_W'(pos_prod_r[1]) +
                   SUM_W'(pos_prod_r[2]) + SUM_W'(dterm_r);
  assign neg_sum = SUM_W'(neg_prod_r[0]) + SUM_W'(neg_prod_r[1]) +
                   SUM_W'(neg_prod_r[2]) + SUM_W'(dterm_r);

  always_ff @(posedge clk) begin
    if (en) begin
      cls_r.sep <= pos_sum[SUM_W-1];
      cls_r.cut <= neg_sum[SUM_W-1];
    end
  end

  assign cls = cls_r;

endmodule

// ----- src/aabb_frustum_classifier.sv -----
// Top level of the box/frustum classifier: plane registers, input stage,
// one afc_plane_eval lane per plane, error checks and the result register.
// Depends on afc_pkg, afc_stream_if and afc_plane_eval.
//
// Takes one box per clock cycle and returns one result per box through the
// input, product, distance-sign and result registers in that order. All planes
// are evaluated in parallel, each lane holding six 16x16 multipliers, so
// throughput is one box per cycle whenever the result side is ready; the whole
// pipeline holds while a result waits. The user must write planes through the
// cfg port only while no transaction is in flight; the block does not enforce
// this. Planes reset to zero, so boxes report a zero-normal error until planes are loaded.
module aabb_frustum_classifier import afc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  afc_box_if.sink              in_box,
  afc_res_if.source            out_res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PLANE_W-1:0]   cfg_wdata
);

  plane_t plane_r [NUM_PLANES];

  logic adv;

  box_t    box_a_r;
  logic    v_a_r, v_b_r, v_c_r, v_d_r;
  status_t status_b_r, status_c_r, status_nxt;
  logic    hint_on_b_r, hint_on_c_r;
  logic [HINT_W-1:0] hint_b_r, hint_c_r;
  result_t res_r, res_nxt;

  plane_class_t cls [NUM_PLANES];
  logic [HINT_SLOTS-1:0] sep_vec;
  logic [HINT_SLOTS-1:0] cut_vec;

  assign adv          = !v_d_r || out_res.ready;
  assign in_box.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_PLANES; k++) begin
        plane_r[k] <= '0;
      end
    end else if (cfg_we) begin
      for (int k = 0; k < NUM_PLANES; k++) begin
        if (cfg_index == CFG_IDX_W'(k)) begin
          plane_r[k] <= cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
    end else if (adv) begin
      v_a_r <= in_box.valid;
      v_b_r <= v_a_r;
      v_c_r <= v_b_r;
      v_d_r <= v_c_r;
    end
  end

  always_comb begin
    status_nxt = ST_OK;
    for (int k = 0; k < NUM_PLANES; k++) begin
      if (plane_r[k][NORMAL_W-1:0] == '0) begin
        status_nxt = ST_ZERO_NORMAL;
      end
    end
    if (box_a_r.hint_valid && (32'(box_a_r.hint_index) >= NUM_PLANES)) begin
      status_nxt = ST_BAD_HINT;
    end
    if ((box_a_r.min_x > box_a_r.max_x) || (box_a_r.min_y > box_a_r.max_y) ||
        (box_a_r.min_z > box_a_r.max_z)) begin
      status_nxt = ST_BAD_BOX;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      box_a_r     <= in_box.data;
      status_b_r  <= status_nxt;
      hint_on_b_r <= box_a_r.hint_valid;
      hint_b_r    <= box_a_r.hint_index;
      status_c_r  <= status_b_r;
      hint_on_c_r <= hint_on_b_r;
      hint_c_r    <= hint_b_r;
      res_r       <= res_nxt;
    end
  end

  for (genvar g = 0; g < NUM_PLANES; g++) begin : g_lane
    afc_plane_eval u_lane (
      .clk   (clk),
      .en    (adv),
      .plane (plane_r[g]),
      .box   (box_a_r),
      .cls   (cls[g])
    );
  end

  always_comb begin
    sep_vec = '0;
    cut_vec = '0;
    for (int k = 0; k < NUM_PLANES; k++) begin
      sep_vec[k] = cls[k].sep;
      cut_vec[k] = cls[k].cut;
    end
  end

  always_comb begin
    res_nxt = '0;
    res_nxt.status = status_c_r;
    if (status_c_r == ST_OK) begin
      if (hint_on_c_r && sep_vec[hint_c_r]) begin
        res_nxt.plane_found      = 1'b1;
        res_nxt.separating_plane = 3'(hint_c_r);
      end else begin
        for (int k = NUM_PLANES - 1; k >= 0; k--) begin
          if (sep_vec[k]) begin
            res_nxt.plane_found      = 1'b1;
            res_nxt.separating_plane = 3'(k);
          end
        end
      end
      if (res_nxt.plane_found) begin
        res_nxt.verdict = VD_OUTSIDE;
      end else if (|cut_vec) begin
        res_nxt.verdict = VD_INTERSECT;
      end else begin
        res_nxt.verdict = VD_INSIDE;
      end
    end
  end

  assign out_res.valid = v_d_r;
  assign out_res.data  = res_r;

endmodule
